/* design/char_lcd_nibble_sequencer_assert.svh */
// Assertion macros shared by the LCD nibble sequencer modules.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef CHAR_LCD_NIBBLE_SEQUENCER_ASSERT_SVH
`define CHAR_LCD_NIBBLE_SEQUENCER_ASSERT_SVH

// The condition must hold at every clock edge outside reset.
`define CLN_ASSERT(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("char lcd sequencer: invariant violated");

// When pre holds at an edge, post must hold at the next edge.
`define CLN_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("char lcd sequencer: sequence violated");

`endif

/* design/cln_pkg.sv */
// Package for the character LCD nibble sequencer: request codes, register
// indexes, reset values, job and configuration types, and helper functions.
// Has no dependencies.
package cln_pkg;

    localparam logic [2:0] FUNC_INIT   = 3'd0;
    localparam logic [2:0] FUNC_CHAR   = 3'd1;
    localparam logic [2:0] FUNC_CMD    = 3'd2;
    localparam logic [2:0] FUNC_CLEAR  = 3'd3;
    localparam logic [2:0] FUNC_CURSOR = 3'd4;

    localparam logic [2:0] CFG_CHAR_DELAY       = 3'd0;
    localparam logic [2:0] CFG_CMD_DELAY        = 3'd1;
    localparam logic [2:0] CFG_CLEAR_DELAY      = 3'd2;
    localparam logic [2:0] CFG_INIT_CLEAR_DELAY = 3'd3;
    localparam logic [2:0] CFG_POWERUP_WAIT     = 3'd4;
    localparam logic [2:0] CFG_SECOND_WAIT      = 3'd5;

    localparam logic [15:0] RST_CHAR_DELAY       = 16'd46;
    localparam logic [15:0] RST_CMD_DELAY        = 16'd40;
    localparam logic [15:0] RST_CLEAR_DELAY      = 16'd500;
    localparam logic [15:0] RST_INIT_CLEAR_DELAY = 16'd1000;
    localparam logic [15:0] RST_POWERUP_WAIT     = 16'd4100;
    localparam logic [15:0] RST_SECOND_WAIT      = 16'd100;

    localparam logic [1:0] DSEL_CHAR       = 2'd0;
    localparam logic [1:0] DSEL_CMD        = 2'd1;
    localparam logic [1:0] DSEL_CLEAR      = 2'd2;
    localparam logic [1:0] DSEL_INIT_CLEAR = 2'd3;

    localparam logic [7:0] LINE1_BASE = 8'h80;
    localparam logic [7:0] LINE2_BASE = 8'hC0;
    localparam logic [7:0] CMD_CLEAR  = 8'h01;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [2:0] INIT_BYTES     = 3'd5;
    localparam logic [2:0] INIT_CLEAR_IDX = 3'd2;

    typedef struct packed {
        logic       is_init;
        logic [7:0] data_byte;
        logic       rs;
        logic [1:0] dsel;
    } t_job;

    typedef struct packed {
        logic [15:0] char_delay;
        logic [15:0] cmd_delay;
        logic [15:0] clear_delay;
        logic [15:0] init_clear_delay;
        logic [15:0] powerup_wait;
        logic [15:0] second_wait;
    } t_cfg;

    // Hold time after a wait: one plus the delay, saturated at full scale.
    function automatic logic [15:0] hold_after(input logic [15:0] d);
        hold_after = (d == 16'hFFFF) ? 16'hFFFF : d + 16'd1;
    endfunction

    // Command bytes that follow the wake nibbles during init.
    function automatic logic [7:0] init_byte(input logic [2:0] idx);
        case (idx)
            3'd0:    init_byte = 8'b0010_1100;
            3'd1:    init_byte = 8'h08;
            3'd2:    init_byte = CMD_CLEAR;
            3'd3:    init_byte = 8'h06;
            default: init_byte = 8'b0000_1100;
        endcase
    endfunction

endpackage

/* design/cln_front.sv */
// Front end of the LCD nibble sequencer: accepts requests and turns each
// valid one into a job descriptor for the queue. Depends on cln_pkg.
module cln_front (
    input  logic            i_valid,
    input  logic [2:0]      i_func,
    input  logic [7:0]      i_value,
    input  logic [5:0]      i_column,
    input  logic            i_row_second,
    input  logic            i_full,
    output logic            o_ready,
    output logic            o_push,
    output cln_pkg::t_job   o_job
);

    logic       known;
    logic [7:0] cursor_byte;

    assign cursor_byte = (i_row_second ? cln_pkg::LINE2_BASE : cln_pkg::LINE1_BASE)
                         + {2'b00, i_column};

    always_comb begin
        known = 1'b1;
        o_job = '0;
        case (i_func)
            cln_pkg::FUNC_INIT: begin
                o_job.is_init = 1'b1;
                o_job.dsel    = cln_pkg::DSEL_CMD;
            end
            cln_pkg::FUNC_CHAR: begin
                o_job.data_byte = i_value;
                o_job.rs        = 1'b1;
                o_job.dsel      = cln_pkg::DSEL_CHAR;
            end
            cln_pkg::FUNC_CMD: begin
                o_job.data_byte = i_value;
                o_job.dsel      = cln_pkg::DSEL_CMD;
            end
            cln_pkg::FUNC_CLEAR: begin
                o_job.data_byte = cln_pkg::CMD_CLEAR;
                o_job.dsel      = cln_pkg::DSEL_CLEAR;
            end
            cln_pkg::FUNC_CURSOR: begin
                o_job.data_byte = cursor_byte;
                o_job.dsel      = cln_pkg::DSEL_CMD;
            end
            default: begin
                known = 1'b0;
            end
        endcase
    end

    // Unknown requests are taken and dropped.
    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full && known;

endmodule

/* design/cln_queue.sv */
// Short job queue between the front and back ends of the LCD sequencer.
// Depends on cln_pkg and the shared assertion header.
`include "char_lcd_nibble_sequencer_assert.svh"

module cln_queue #(
    parameter int DEPTH = cln_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  cln_pkg::t_job   i_job,
    input  logic            i_pop,
    output logic            o_valid,
    output logic            o_full,
    output cln_pkg::t_job   o_job
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    cln_pkg::t_job r_mem [DEPTH];
    logic [AW-1:0] r_wptr, n_wptr;
    logic [AW-1:0] r_rptr, n_rptr;
    logic [CW-1:0] r_count, n_count;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == LAST_PTR) ? '0 : r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = (r_rptr == LAST_PTR) ? '0 : r_rptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == FULL_CNT);
    assign o_job   = r_mem[r_rptr];

    `CLN_ASSERT(a_count_bound, r_count <= FULL_CNT)
    `CLN_ASSERT(a_no_pop_empty, !i_pop || (r_count != '0))
    `CLN_ASSERT(a_no_push_full, !i_push || (r_count != FULL_CNT))

endmodule

/* design/cln_back.sv */
// Back end of the LCD nibble sequencer: walks each job through its pin
// events into a registered output stage. Depends on cln_pkg and the
// shared assertion header.
`include "char_lcd_nibble_sequencer_assert.svh"

module cln_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  cln_pkg::t_cfg   i_cfg,
    input  logic            i_job_valid,
    input  cln_pkg::t_job   i_job,
    output logic            o_pop,
    input  logic            i_ready,
    output logic            o_valid,
    output logic [3:0]      o_nibble,
    output logic            o_reg_select,
    output logic            o_enable,
    output logic [15:0]     o_hold_us,
    output logic            o_last
);

    logic       r_busy, n_busy;
    logic       r_init, n_init;
    logic       r_wake, n_wake;
    logic [2:0] r_wcnt, n_wcnt;
    logic [2:0] r_bidx, n_bidx;
    logic [2:0] r_step, n_step;
    logic [7:0] r_byte;
    logic       r_rs;
    logic [1:0] r_dsel;

    logic        r_out_valid;
    logic [3:0]  r_out_nibble;
    logic        r_out_rs;
    logic        r_out_enable;
    logic [15:0] r_out_hold;
    logic        r_out_last;

    logic        advance;
    logic [3:0]  cur_nibble;
    logic        cur_rs;
    logic        cur_enable;
    logic [15:0] cur_hold;
    logic        cur_last;
    logic [7:0]  cur_byte;
    logic [1:0]  cur_dsel;
    logic [15:0] cur_delay;
    logic [1:0]  sub;
    logic [1:0]  wk;
    logic [15:0] wake_hold;

    assign advance = r_busy && (!r_out_valid || i_ready);

    always_comb begin
        cur_byte = r_init ? cln_pkg::init_byte(r_bidx) : r_byte;
        if (r_init) begin
            cur_dsel = (r_bidx == cln_pkg::INIT_CLEAR_IDX) ? cln_pkg::DSEL_INIT_CLEAR
                                                           : cln_pkg::DSEL_CMD;
        end else begin
            cur_dsel = r_dsel;
        end
        case (cur_dsel)
            cln_pkg::DSEL_CHAR:       cur_delay = i_cfg.char_delay;
            cln_pkg::DSEL_CMD:        cur_delay = i_cfg.cmd_delay;
            cln_pkg::DSEL_CLEAR:      cur_delay = i_cfg.clear_delay;
            cln_pkg::DSEL_INIT_CLEAR: cur_delay = i_cfg.init_clear_delay;
            default:                  cur_delay = i_cfg.cmd_delay;
        endcase

        wk = r_wcnt[2:1];
        case (wk)
            2'd0:    wake_hold = cln_pkg::hold_after(i_cfg.powerup_wait);
            2'd1:    wake_hold = cln_pkg::hold_after(i_cfg.second_wait);
            2'd2:    wake_hold = 16'd1;
            default: wake_hold = cln_pkg::hold_after(i_cfg.cmd_delay);
        endcase

        sub = (r_step >= 3'd3) ? 2'(r_step - 3'd3) : r_step[1:0];

        if (r_wake) begin
            cur_nibble = (wk == 2'd3) ? 4'h2 : 4'h3;
            cur_rs     = 1'b0;
            cur_enable = !r_wcnt[0];
            cur_hold   = r_wcnt[0] ? wake_hold : 16'd1;
            cur_last   = 1'b0;
        end else begin
            cur_nibble = (r_step < 3'd3) ? cur_byte[7:4] : cur_byte[3:0];
            cur_rs     = r_init ? 1'b0 : r_rs;
            cur_enable = (sub == 2'd1);
            cur_hold   = (sub == 2'd2) ? cln_pkg::hold_after(cur_delay) : 16'd1;
            cur_last   = (r_step == 3'd5)
                         && (!r_init || (r_bidx == cln_pkg::INIT_BYTES - 3'd1));
        end
    end

    assign o_pop = i_job_valid && (!r_busy || (advance && cur_last));

    always_comb begin
        n_busy = r_busy;
        n_init = r_init;
        n_wake = r_wake;
        n_wcnt = r_wcnt;
        n_bidx = r_bidx;
        n_step = r_step;
        if (advance) begin
            if (r_wake) begin
                if (r_wcnt == 3'd7) begin
                    n_wake = 1'b0;
                    n_step = '0;
                    n_bidx = '0;
                end else begin
                    n_wcnt = r_wcnt + 3'd1;
                end
            end else if (r_step == 3'd5) begin
                n_step = '0;
                if (cur_last) begin
                    n_busy = 1'b0;
                end else begin
                    n_bidx = r_bidx + 3'd1;
                end
            end else begin
                n_step = r_step + 3'd1;
            end
        end
        if (o_pop) begin
            n_busy = 1'b1;
            n_init = i_job.is_init;
            n_wake = i_job.is_init;
            n_wcnt = '0;
            n_bidx = '0;
            n_step = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_init      <= 1'b0;
            r_wake      <= 1'b0;
            r_wcnt      <= '0;
            r_bidx      <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_init <= n_init;
            r_wake <= n_wake;
            r_wcnt <= n_wcnt;
            r_bidx <= n_bidx;
            r_step <= n_step;
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_byte <= i_job.data_byte;
            r_rs   <= i_job.rs;
            r_dsel <= i_job.dsel;
        end
        if (advance) begin
            r_out_nibble <= cur_nibble;
            r_out_rs     <= cur_rs;
            r_out_enable <= cur_enable;
            r_out_hold   <= cur_hold;
            r_out_last   <= cur_last;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_nibble     = r_out_nibble;
    assign o_reg_select = r_out_rs;
    assign o_enable     = r_out_enable;
    assign o_hold_us    = r_out_hold;
    assign o_last       = r_out_last;

    `CLN_ASSERT(a_wake_in_init, !r_wake || r_init)
    `CLN_ASSERT(a_step_bound, !r_busy || (r_step <= 3'd5 && r_bidx < cln_pkg::INIT_BYTES))
    `CLN_ASSERT(a_strobe_short, !(r_out_valid && r_out_enable) || (r_out_hold == 16'd1))
    `CLN_ASSERT_NEXT(a_idle_after_last, advance && cur_last && !i_job_valid, !r_busy)

endmodule

/* design/char_lcd_nibble_sequencer.sv */
// Top level of the character LCD 4-bit nibble sequencer: configuration
// registers plus the front end, job queue and back end.
// Depends on cln_pkg, cln_front, cln_queue and cln_back.
//
// Usage:
//   Requests enter on the s_axis channel: tuser carries the request code
//   (init, print character, write command, clear, move cursor) and tdata
//   the character or command byte, the cursor column and the line select.
//   Unknown request codes are taken and produce nothing.
//   Pin events leave on the m_axis channel, one per transfer; tlast marks
//   the final event of a request and tuser carries RS.
//   Delay registers are written on the cfg channel, which is always ready;
//   write them only while no request is in flight.
// Timing:
//   The first event of a request passes the job queue, the back end state registers
//   and the output register. The back end emits one event per cycle while
//   m_axis_tready is high; an ordinary request is a high and a low nibble as setup,
//   enable strobe and hold events, and init sends wake nibbles before its command
//   bytes. The next queued request is taken in the cycle that registers the previous
//   last event. A four-entry job queue lets requests be accepted while events drain.
// Reset and stalls:
//   Reset empties the queue and output stage and restores default delays.
//   While m_axis_tready is low the output event holds; the queue then
//   fills and s_axis_tready drops once it is full.
module char_lcd_nibble_sequencer #(
    parameter int QUEUE_DEPTH = cln_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // value[7:0], column[13:8], row_second[14], 0[15]
    input  logic [2:0]  i_s_axis_tuser,   // func[2:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // nibble[3:0], enable[4], hold_us[20:5], 0[23:21]
    output logic        o_m_axis_tuser,   // reg_select[0]
    output logic        o_m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    cln_pkg::t_cfg r_cfg;
    cln_pkg::t_job front_job;
    cln_pkg::t_job queue_job;
    logic          push;
    logic          pop;
    logic          q_valid;
    logic          q_full;
    logic [3:0]    ev_nibble;
    logic          ev_enable;
    logic [15:0]   ev_hold;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.char_delay       <= cln_pkg::RST_CHAR_DELAY;
            r_cfg.cmd_delay        <= cln_pkg::RST_CMD_DELAY;
            r_cfg.clear_delay      <= cln_pkg::RST_CLEAR_DELAY;
            r_cfg.init_clear_delay <= cln_pkg::RST_INIT_CLEAR_DELAY;
            r_cfg.powerup_wait     <= cln_pkg::RST_POWERUP_WAIT;
            r_cfg.second_wait      <= cln_pkg::RST_SECOND_WAIT;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                cln_pkg::CFG_CHAR_DELAY:       r_cfg.char_delay       <= i_cfg_data;
                cln_pkg::CFG_CMD_DELAY:        r_cfg.cmd_delay        <= i_cfg_data;
                cln_pkg::CFG_CLEAR_DELAY:      r_cfg.clear_delay      <= i_cfg_data;
                cln_pkg::CFG_INIT_CLEAR_DELAY: r_cfg.init_clear_delay <= i_cfg_data;
                cln_pkg::CFG_POWERUP_WAIT:     r_cfg.powerup_wait     <= i_cfg_data;
                cln_pkg::CFG_SECOND_WAIT:      r_cfg.second_wait      <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    cln_front u_front (
        .i_valid      (i_s_axis_tvalid),
        .i_func       (i_s_axis_tuser),
        .i_value      (i_s_axis_tdata[7:0]),
        .i_column     (i_s_axis_tdata[13:8]),
        .i_row_second (i_s_axis_tdata[14]),
        .i_full       (q_full),
        .o_ready      (o_s_axis_tready),
        .o_push       (push),
        .o_job        (front_job)
    );

    cln_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_job   (queue_job)
    );

    cln_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_job_valid  (q_valid),
        .i_job        (queue_job),
        .o_pop        (pop),
        .i_ready      (i_m_axis_tready),
        .o_valid      (o_m_axis_tvalid),
        .o_nibble     (ev_nibble),
        .o_reg_select (o_m_axis_tuser),
        .o_enable     (ev_enable),
        .o_hold_us    (ev_hold),
        .o_last       (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {3'b000, ev_hold, ev_enable, ev_nibble};

endmodule
